// ===== hw/rtl/bis_pkg.sv =====
package bis_pkg;

    localparam int COLUMN_W   = 10;
    localparam int ROW_W      = 10;
    localparam int PIXEL_W    = 8;
    localparam int SIZE_W     = 10;
    localparam int STEP_W     = 26;
    localparam int CFG_DATA_W = 26;
    localparam int POS_W      = COLUMN_W + STEP_W;

    localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RESET  = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RESET = SIZE_W'(512);
    localparam logic [STEP_W-1:0] X_STEP_RESET        = STEP_W'(65536);
    localparam logic [STEP_W-1:0] Y_STEP_RESET        = STEP_W'(65536);

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    typedef enum logic [1:0] {
        CFG_SOURCE_WIDTH,
        CFG_SOURCE_HEIGHT,
        CFG_X_STEP,
        CFG_Y_STEP
    } cfg_index_t;

    // pixel values and interpolation steps, signed with headroom
    typedef logic signed [9:0] sval_t;

    function automatic sval_t to_sval(input logic [PIXEL_W-1:0] v);
        return sval_t'({2'b00, v});
    endfunction

endpackage

// ===== hw/rtl/bis_job_if.sv =====
interface bis_job_if;
    import bis_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row_index;
    logic [PIXEL_W-1:0]  pixel_in;

    modport source (output valid, output operation, output column, output row_index,
                    output pixel_in, input ready);
    modport sink   (input valid, input operation, input column, input row_index,
                    input pixel_in, output ready);
endinterface

// ===== hw/rtl/bis_result_if.sv =====
interface bis_result_if;
    import bis_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIXEL_W-1:0]  pixel_out;
    logic [COLUMN_W-1:0] out_column;
    logic [ROW_W-1:0]    out_row;

    modport source (output valid, output pixel_out, output out_column, output out_row,
                    input ready);
    modport sink   (input valid, input pixel_out, input out_column, input out_row,
                    output ready);
endinterface

// ===== hw/rtl/bilinear_image_scaler.sv =====
// Bilinear image scaler. Store items write one gray source pixel into the frame
// memory (MAX_WIDTH x MAX_HEIGHT entries, address row * MAX_WIDTH + column);
// stores outside the frame are dropped. Compute items name a destination pixel,
// which maps back to source position column * x_step and row_index * y_step
// (FRAC_BITS fraction bits); the four neighbours are blended vertically then
// horizontally with round-half-even and one result item follows. A compute item
// occupies the block from acceptance until its result is loaded into the output
// register: both coordinates are multiplied at acceptance, then come the
// edge-handling step, four reads through the single port of the frame memory
// and the blend steps S_L1 to S_L5 on the shared blend multiplier. The output
// register frees the input side while a result waits to be taken. Frame memory
// contents are not cleared at reset; read only pixels that were stored. Write
// the size and step registers only while no item is in flight.
module bilinear_image_scaler #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  bis_pkg::cfg_index_t             cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data,
    bis_job_if.sink                         job,
    bis_result_if.source                    result
);
    import bis_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int IW     = POS_W - FRAC_BITS;
    localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int SZW    = $clog2(MAXDIM + 1);
    localparam int EW     = ((IW > SZW) ? IW : SZW) + 1;
    localparam int PRW    = FRAC_BITS + 12;

    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_RA, S_RB, S_RC, S_RD, S_L1, S_L2, S_L3, S_L4, S_L5
    } state_t;

    state_t state_reg;

    logic [SIZE_W-1:0] source_width_reg;
    logic [SIZE_W-1:0] source_height_reg;
    logic [STEP_W-1:0] x_step_reg;
    logic [STEP_W-1:0] y_step_reg;

    logic [COLUMN_W-1:0] col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [POS_W-1:0]    pos_x_reg;
    logic [POS_W-1:0]    pos_y_reg;
    logic [CW-1:0]       ix_reg;
    logic [RW-1:0]       iy_reg;
    logic [FRAC_BITS-1:0] fx_reg;
    logic [FRAC_BITS-1:0] fy_reg;
    logic [PIXEL_W-1:0]  a_reg, b_reg, c_reg, d_reg;
    sval_t               m1_reg, m2_reg;
    logic signed [PRW-1:0] prod_reg;

    logic                out_valid_reg;
    logic [PIXEL_W-1:0]  pixel_out_reg;
    logic [COLUMN_W-1:0] out_column_reg;
    logic [ROW_W-1:0]    out_row_reg;

    logic               job_accept;
    logic               in_frame;
    logic               mem_we;
    logic [AW-1:0]      mem_addr;
    logic [AW-1:0]      store_addr;
    logic [AW-1:0]      rd_base;
    logic [PIXEL_W-1:0] mem_rdata;

    logic [EW-1:0] w_size, h_size;
    logic [EW-1:0] ix_full, iy_full;

    logic [FRAC_BITS-1:0]  frac_sel;
    sval_t                 lo_sel, hi_sel;
    logic signed [10:0]    diff_sel;
    logic signed [PRW-1:0] prod_next;
    sval_t                 rnd;
    sval_t                 m1_next, m2_next;
    logic signed [10:0]    p_wide;
    logic [PIXEL_W-1:0]    p_sat;

    function automatic logic [EW-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                 input logic [EW-1:0] maxv);
        logic [EW-1:0] e;
        e = EW'(v);
        if (e < EW'(2))
        begin
            e = EW'(2);
        end
        else if (e > maxv)
        begin
            e = maxv;
        end
        return e;
    endfunction

    function automatic logic [EW-1:0] map_int(input logic [IW-1:0] ip,
                                              input logic [EW-1:0] size);
        logic [EW-1:0] i;
        i = EW'(ip);
        if (i >= size - EW'(1))
        begin
            i = i - EW'(1);
        end
        if (i > size - EW'(2))
        begin
            i = size - EW'(2);
        end
        return i;
    endfunction

    // round half to even of prod / 2^FRAC_BITS
    function automatic sval_t round_prod(input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] q;
        logic [FRAC_BITS-1:0]  rem;
        q   = p >>> FRAC_BITS;
        rem = p[FRAC_BITS-1:0];
        if (rem > HALF || (rem == HALF && q[0]))
        begin
            q = q + PRW'(1);
        end
        return sval_t'(q[9:0]);
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg  <= SOURCE_WIDTH_RESET;
            source_height_reg <= SOURCE_HEIGHT_RESET;
            x_step_reg        <= X_STEP_RESET;
            y_step_reg        <= Y_STEP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SOURCE_WIDTH:  source_width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: source_height_reg <= cfg_data[SIZE_W-1:0];
                CFG_X_STEP:        x_step_reg        <= cfg_data[STEP_W-1:0];
                CFG_Y_STEP:        y_step_reg        <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign job.ready  = (state_reg == S_IDLE);
    assign job_accept = job.valid && job.ready;

    assign in_frame   = (32'(job.column) < MAX_WIDTH) && (32'(job.row_index) < MAX_HEIGHT);
    assign mem_we     = job_accept && (job.operation == OP_STORE) && in_frame;
    assign store_addr = AW'(job.row_index) * AW'(MAX_WIDTH) + AW'(job.column);
    assign rd_base    = AW'(iy_reg) * AW'(MAX_WIDTH) + AW'(ix_reg);

    always_comb
    begin
        case (state_reg)
            S_IDLE:  mem_addr = store_addr;
            S_RB:    mem_addr = rd_base + AW'(MAX_WIDTH);
            S_RC:    mem_addr = rd_base + AW'(1);
            S_RD:    mem_addr = rd_base + AW'(MAX_WIDTH) + AW'(1);
            default: mem_addr = rd_base;
        endcase
    end

    bis_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (job.pixel_in),
        .rdata (mem_rdata)
    );

    // edge handling of the mapped coordinates
    assign w_size  = clamp_size(source_width_reg, EW'(MAX_WIDTH));
    assign h_size  = clamp_size(source_height_reg, EW'(MAX_HEIGHT));
    assign ix_full = map_int(pos_x_reg[POS_W-1:FRAC_BITS], w_size);
    assign iy_full = map_int(pos_y_reg[POS_W-1:FRAC_BITS], h_size);

    // shared blend multiplier
    always_comb
    begin
        frac_sel = fy_reg;
        lo_sel   = to_sval(a_reg);
        hi_sel   = to_sval(b_reg);
        case (state_reg)
            S_L2:
            begin
                lo_sel = to_sval(c_reg);
                hi_sel = to_sval(d_reg);
            end
            S_L4:
            begin
                frac_sel = fx_reg;
                lo_sel   = m1_reg;
                hi_sel   = m2_reg;
            end
            default: ;
        endcase
        diff_sel  = {hi_sel[9], hi_sel} - {lo_sel[9], lo_sel};
        prod_next = PRW'($signed({1'b0, frac_sel})) * PRW'(diff_sel);
    end

    assign rnd     = round_prod(prod_reg);
    assign m1_next = to_sval(a_reg) + rnd;
    assign m2_next = to_sval(c_reg) + rnd;
    assign p_wide  = {m1_reg[9], m1_reg} + {rnd[9], rnd};

    always_comb
    begin
        if (p_wide < 11'sd0)
        begin
            p_sat = '0;
        end
        else if (p_wide > 11'sd255)
        begin
            p_sat = '1;
        end
        else
        begin
            p_sat = p_wide[PIXEL_W-1:0];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (job_accept)
        begin
            col_reg   <= job.column;
            row_reg   <= job.row_index;
            pos_x_reg <= POS_W'(job.column) * POS_W'(x_step_reg);
            pos_y_reg <= POS_W'(job.row_index) * POS_W'(y_step_reg);
        end
        case (state_reg)
            S_EDGE:
            begin
                ix_reg <= ix_full[CW-1:0];
                iy_reg <= iy_full[RW-1:0];
                fx_reg <= pos_x_reg[FRAC_BITS-1:0];
                fy_reg <= pos_y_reg[FRAC_BITS-1:0];
            end
            S_RB: a_reg <= mem_rdata;
            S_RC: b_reg <= mem_rdata;
            S_RD: c_reg <= mem_rdata;
            S_L1:
            begin
                d_reg    <= mem_rdata;
                prod_reg <= prod_next;
            end
            S_L2:
            begin
                m1_reg   <= m1_next;
                prod_reg <= prod_next;
            end
            S_L3: m2_reg <= m2_next;
            S_L4: prod_reg <= prod_next;
            default: ;
        endcase
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pixel_out_reg  <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else
        begin
            if (state_reg == S_L5 && (!out_valid_reg || result.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (job.valid && job.operation == OP_COMPUTE)
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE: state_reg <= S_RA;
                S_RA:   state_reg <= S_RB;
                S_RB:   state_reg <= S_RC;
                S_RC:   state_reg <= S_RD;
                S_RD:   state_reg <= S_L1;
                S_L1:   state_reg <= S_L2;
                S_L2:   state_reg <= S_L3;
                S_L3:   state_reg <= S_L4;
                S_L4:   state_reg <= S_L5;
                S_L5:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        pixel_out_reg  <= p_sat;
                        out_column_reg <= col_reg;
                        out_row_reg    <= row_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.pixel_out  = pixel_out_reg;
    assign result.out_column = out_column_reg;
    assign result.out_row    = out_row_reg;

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_IDLE)
        else $error("frame write outside idle");

    a_compute_start: assert property (@(posedge clk) disable iff (!rst_n)
        (job_accept && job.operation == OP_COMPUTE) |=> state_reg == S_EDGE)
        else $error("compute item did not start");

    a_neighbours_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RA |->
            (EW'(ix_reg) + EW'(1) < w_size) && (EW'(iy_reg) + EW'(1) < h_size))
        else $error("neighbour outside source image");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_L5))
        else $error("result loaded outside last blend step");

endmodule

// ===== hw/rtl/bis_ram.sv =====
module bis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ===== tb/tb_bilinear_image_scaler.sv =====
`timescale 1ns / 100ps

module tb_bilinear_image_scaler;
    import bis_pkg::*;

    localparam int MAX_W      = 512;
    localparam int MAX_H      = 512;
    localparam int STEP_ONE   = 65536;
    localparam int ITEMS_EACH = 146;
    localparam int TAIL       = 16;
    localparam int LIMIT      = 1000000;

    typedef struct packed {
        logic [PIXEL_W-1:0]  pixel;
        logic [COLUMN_W-1:0] col;
        logic [ROW_W-1:0]    row;
    } scaled_px_t;

    typedef struct packed {
        int   w;
        int   h;
        int   xs;
        int   ys;
        logic op;
        int   col;
        int   row;
        int   pix;
        logic pinned;
        int   px;
    } dir_row_t;

    // size and step settings, item, then the typed-in result where it is obvious
    localparam dir_row_t DIR_TAB [25] = '{
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,      0,    0,   0, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,      1,    0, 255, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,      0,    1, 255, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,      1,    1,   0, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,      0,    2, 128, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,      1,    2,   7, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,    510,  510, 255, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,    511,  510,   0, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,    510,  511,   1, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,    511,  511, 254, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,    512,    0, 170, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,      0,  512,  85, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_STORE,   1023, 1023, 255, 0,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_COMPUTE,    0,    0,   0, 1,   0},
        '{512, 512, STEP_ONE, STEP_ONE, OP_COMPUTE,    0,    1, 255, 1, 255},
        '{512, 512, STEP_ONE, STEP_ONE, OP_COMPUTE,  511,  511,   0, 1, 255},
        '{512, 512, STEP_ONE, STEP_ONE, OP_COMPUTE, 1023, 1023, 255, 1, 255},
        '{512, 512, 32768, STEP_ONE,    OP_COMPUTE,    1,    0,   0, 1, 128},
        '{512, 512, 32768, STEP_ONE,    OP_COMPUTE,    1,    1, 255, 1, 127},
        '{512, 512, 0, 0,               OP_COMPUTE, 1023, 1023,   0, 1,   0},
        '{0, 1023, STEP_ONE, STEP_ONE,  OP_COMPUTE,    5,    0,   0, 1,   0},
        '{0, 1023, STEP_ONE, STEP_ONE,  OP_COMPUTE,    0,    1,   0, 1, 255},
        '{2, 3, STEP_ONE, STEP_ONE,     OP_COMPUTE,    1,    1,   0, 1, 255},
        '{2, 3, STEP_ONE, STEP_ONE,     OP_COMPUTE,    0,    2,   0, 1, 255},
        '{2, 3, 98304, 49152,           OP_COMPUTE,    1,    1,   0, 0,   0}
    };

    logic clk;
    logic rst_n;
    logic cfg_write;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bis_job_if    job_ch ();
    bis_result_if res_ch ();

    bilinear_image_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job       (job_ch),
        .result    (res_ch)
    );

    logic [SIZE_W-1:0] src_w;
    logic [SIZE_W-1:0] src_h;
    logic [STEP_W-1:0] x_step_r;
    logic [STEP_W-1:0] y_step_r;
    logic [PIXEL_W-1:0] frame_px [MAX_W*MAX_H];
    bit frame_set [MAX_W*MAX_H];

    scaled_px_t pending_px [$];
    int fail_count;
    int cycle_count;
    int sent_count;
    int send_idle_pct;
    int recv_idle_pct;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int eff_size(input int v, input int maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic void map_coord(input int idx, input int step, input int size,
                                      output int ip, output int fp);
        longint pos;
        longint i;
        pos = longint'(idx) * longint'(step);
        i = pos >>> 16;
        if (i >= size - 1)
            i = i - 1;
        if (i > size - 2)
            i = size - 2;
        ip = int'(i);
        fp = int'(pos & 65535);
    endfunction

    // a + (b - a) * frac, rounded half to even
    function automatic int blend_q16(input int a, input int b, input int frac);
        longint p;
        longint r;
        longint rem;
        p = longint'(frac) * longint'(b - a);
        r = p >>> 16;
        rem = p & 65535;
        if (rem > 32768 || (rem == 32768 && (r & 1) != 0))
            r = r + 1;
        return a + int'(r);
    endfunction

    function automatic logic [PIXEL_W-1:0] predict_px(input int col, input int row);
        int w, h, ix, iy, fx, fy, a, b, c, d, m1, m2, p;
        w = eff_size(int'(src_w), MAX_W);
        h = eff_size(int'(src_h), MAX_H);
        map_coord(col, int'(x_step_r), w, ix, fx);
        map_coord(row, int'(y_step_r), h, iy, fy);
        a = int'(frame_px[iy * MAX_W + ix]);
        b = int'(frame_px[(iy + 1) * MAX_W + ix]);
        c = int'(frame_px[iy * MAX_W + ix + 1]);
        d = int'(frame_px[(iy + 1) * MAX_W + ix + 1]);
        m1 = blend_q16(a, b, fy);
        m2 = blend_q16(c, d, fy);
        p = blend_q16(m1, m2, fx);
        if (p < 0)
            p = 0;
        if (p > 255)
            p = 255;
        return PIXEL_W'(p);
    endfunction

    function automatic int pick_dest(input int size, input int step);
        longint lim;
        if (step == 0 || $urandom_range(4) == 0)
            return $urandom_range(1023);
        lim = (longint'(size) << 16) / step + 1;
        if (lim > 1023)
            lim = 1023;
        return $urandom_range(int'(lim));
    endfunction

    task automatic send_item(input logic op, input int col, input int row, input int pix,
                             input logic pinned, input int pinned_px);
        scaled_px_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            job_ch.valid <= 1'b0;
            @(posedge clk);
        end
        job_ch.valid     <= 1'b1;
        job_ch.operation <= op;
        job_ch.column    <= COLUMN_W'(col);
        job_ch.row_index <= ROW_W'(row);
        job_ch.pixel_in  <= PIXEL_W'(pix);
        do
            @(posedge clk);
        while (!job_ch.ready);
        sent_count++;
        if (op == OP_STORE)
        begin
            // stores outside the frame are dropped
            if (col < MAX_W && row < MAX_H)
            begin
                frame_px[row * MAX_W + col] = PIXEL_W'(pix);
                frame_set[row * MAX_W + col] = 1'b1;
            end
        end
        else
        begin
            want.pixel = pinned ? PIXEL_W'(pinned_px) : predict_px(col, row);
            want.col = COLUMN_W'(col);
            want.row = ROW_W'(row);
            pending_px.push_back(want);
        end
    endtask

    task automatic wait_idle();
        job_ch.valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        case (idx)
            CFG_SOURCE_WIDTH:  src_w = SIZE_W'(val);
            CFG_SOURCE_HEIGHT: src_h = SIZE_W'(val);
            CFG_X_STEP:        x_step_r = STEP_W'(val);
            CFG_Y_STEP:        y_step_r = STEP_W'(val);
            default: ;
        endcase
    endtask

    task automatic set_config(input int w, input int h, input int xs, input int ys);
        wait_idle();
        write_reg(CFG_SOURCE_WIDTH, w);
        write_reg(CFG_SOURCE_HEIGHT, h);
        write_reg(CFG_X_STEP, xs);
        write_reg(CFG_Y_STEP, ys);
        cfg_write <= 1'b0;
    endtask

    task automatic random_item();
        int w, h, col, row, ix, iy, fx, fy, dx, dy;
        w = eff_size(int'(src_w), MAX_W);
        h = eff_size(int'(src_h), MAX_H);
        if ($urandom_range(99) < 30)
        begin
            if ($urandom_range(9) == 0)
            begin
                col = $urandom_range(1023);
                row = $urandom_range(1023);
            end
            else
            begin
                col = $urandom_range(w - 1);
                row = $urandom_range(h - 1);
            end
            send_item(OP_STORE, col, row, $urandom_range(255), 1'b0, 0);
        end
        else
        begin
            col = pick_dest(w, int'(x_step_r));
            row = pick_dest(h, int'(y_step_r));
            map_coord(col, int'(x_step_r), w, ix, fx);
            map_coord(row, int'(y_step_r), h, iy, fy);
            // load any neighbour not yet in the frame store
            for (dy = 0; dy < 2; dy++)
            begin
                for (dx = 0; dx < 2; dx++)
                begin
                    if (!frame_set[(iy + dy) * MAX_W + ix + dx])
                        send_item(OP_STORE, ix + dx, iy + dy, $urandom_range(255), 1'b0, 0);
                end
            end
            send_item(OP_COMPUTE, col, row, $urandom_range(255), 1'b0, 0);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_side
        scaled_px_t want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_px.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result: expected none, actual %0d at (%0d,%0d)",
                             $time, res_ch.pixel_out, res_ch.out_column, res_ch.out_row);
                end
                else
                begin
                    want = pending_px.pop_front();
                    check_field("pixel_out", int'(want.pixel), int'(res_ch.pixel_out));
                    check_field("out_column", int'(want.col), int'(res_ch.out_column));
                    check_field("out_row", int'(want.row), int'(res_ch.out_row));
                end
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        dir_row_t r;
        int i;
        int ph;
        int target;
        sent_count = 0;
        send_idle_pct = 26;
        recv_idle_pct = 71;
        src_w = SOURCE_WIDTH_RESET;
        src_h = SOURCE_HEIGHT_RESET;
        x_step_r = X_STEP_RESET;
        y_step_r = Y_STEP_RESET;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_SOURCE_WIDTH;
        cfg_data <= '0;
        job_ch.valid <= 1'b0;
        job_ch.operation <= OP_STORE;
        job_ch.column <= '0;
        job_ch.row_index <= '0;
        job_ch.pixel_in <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 25; i++)
        begin
            r = DIR_TAB[i];
            if (r.w != int'(src_w) || r.h != int'(src_h) ||
                r.xs != int'(x_step_r) || r.ys != int'(y_step_r))
                set_config(r.w, r.h, r.xs, r.ys);
            send_item(r.op, r.col, r.row, r.pix, r.pinned, r.px);
        end

        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_config(2, 2, 1, 1);
                1: set_config(512, 512, 33554432, 33554432);
                2: set_config($urandom_range(512, 2), $urandom_range(512, 2),
                              $urandom_range(262144, 4096), $urandom_range(262144, 4096));
                3: set_config($urandom_range(512, 2), $urandom_range(512, 2),
                              $urandom_range(67108863), $urandom_range(67108863));
                4: set_config(512, 2, $urandom_range(131072, 32768), $urandom_range(131072));
                default: set_config($urandom_range(64, 2), $urandom_range(64, 2),
                                    $urandom_range(196608, 8192), $urandom_range(196608, 8192));
            endcase
            if (ph < 2)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 71;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 71;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            target = sent_count + ITEMS_EACH;
            while (sent_count < target)
                random_item();
        end

        wait_idle();
        if (fail_count == 0 && pending_px.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
